### hdl/bmm_pkg.sv
// Package for the bipartite matching core: operation codes, widths and the
// controller-to-datapath command and status structs. No dependencies.
`default_nettype none
package bmm_pkg;
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic REG_LEFT_COUNT  = 1'b0;
  localparam logic REG_RIGHT_COUNT = 1'b1;

  localparam int unsigned CountW = 9;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned OpW    = 2;

  // One-hot command strobes from the controller.
  typedef struct packed {
    logic add_edge;
    logic clear_start;
    logic solve_start;
  } bmm_cmd_t;

  // Status returned by the datapath.
  typedef struct packed {
    logic busy;
    logic done;
  } bmm_sts_t;
endpackage
`default_nettype wire

### hdl/bmm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stands alone; used for the adjacency bitmap, the owner table and the stack.
`default_nettype none
module bmm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### hdl/bmm_datapath.sv
// Datapath of the matching core: bitmap rows, owner table, visited marks,
// search stack and the step sequencer for clear and solve.
// Depends on bmm_pkg and bmm_ram.
`default_nettype none
module bmm_datapath #(
  parameter int unsigned MaxLeft  = 256,
  parameter int unsigned MaxRight = 256
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire bmm_pkg::bmm_cmd_t       cmd_i,
  input  wire logic [bmm_pkg::IdxW-1:0] left_i,
  input  wire logic [bmm_pkg::IdxW-1:0] right_i,
  input  wire logic [bmm_pkg::CountW-1:0] left_count_i,
  input  wire logic [bmm_pkg::CountW-1:0] right_count_i,
  output bmm_pkg::bmm_sts_t            sts_o,
  output logic [bmm_pkg::CountW-1:0]   count_o
);
  import bmm_pkg::*;

  localparam int unsigned LW   = (MaxLeft > 1) ? $clog2(MaxLeft) : 1;
  localparam int unsigned RW   = (MaxRight > 1) ? $clog2(MaxRight) : 1;
  localparam int unsigned LCW  = $clog2(MaxLeft + 1);
  localparam int unsigned RCW  = $clog2(MaxRight + 1);
  localparam int unsigned SW   = $clog2(MaxLeft + 2);
  localparam int unsigned SD   = MaxLeft + 1;
  localparam int unsigned SAW  = $clog2(SD);
  localparam int unsigned OwnW = LW + 1;

  // Step codes.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_OINIT  = 4'd2;
  localparam logic [3:0] S_ROOT   = 4'd3;
  localparam logic [3:0] S_TOP    = 4'd4;
  localparam logic [3:0] S_TOPW   = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_OWNW   = 4'd7;
  localparam logic [3:0] S_OWN    = 4'd8;
  localparam logic [3:0] S_FLIP   = 4'd9;
  localparam logic [3:0] S_FLIPW  = 4'd10;
  localparam logic [3:0] S_FLIPD  = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0]          step_q, step_d;
  logic [LCW-1:0]      nl;
  logic [RCW-1:0]      nr;
  logic [LCW-1:0]      root_q, root_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [SW-1:0]       sp_q, sp_d;
  logic [SW-1:0]       k_q, k_d;
  logic [LW-1:0]       node_q, node_d;
  logic [RCW-1:0]      cur_q, cur_d;
  logic [LCW-1:0]      wipe_q, wipe_d;
  logic [MaxRight-1:0] vis_q, vis_d;
  logic [MaxRight-1:0] ownd_q, ownd_d;

  // Clamp the counts to the array sizes.
  assign nl = (32'(left_count_i) > MaxLeft) ? LCW'(MaxLeft) : LCW'(left_count_i);
  assign nr = (32'(right_count_i) > MaxRight) ? RCW'(MaxRight) : RCW'(right_count_i);

  // Adjacency rows, one row per left node.
  logic            adj_we;
  logic [LW-1:0]   adj_waddr, adj_raddr;
  logic [MaxRight-1:0] adj_wdata, adj_rdata;
  logic [MaxRight-1:0] row_q;
  logic            row_load;

  bmm_ram #(.Width(MaxRight), .Depth(MaxLeft)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );

  // Owner table: left node for each right node.
  logic            own_we;
  logic [RW-1:0]   own_waddr, own_raddr;
  logic [LW-1:0]   own_wdata, own_rdata;
  bmm_ram #(.Width(LW), .Depth(MaxRight)) u_own (
    .clk_i, .we_i(own_we), .waddr_i(own_waddr), .wdata_i(own_wdata),
    .raddr_i(own_raddr), .rdata_o(own_rdata)
  );

  // Search stack: node, cursor and chosen right node per frame.
  localparam int unsigned FW = LW + RCW + RW;
  logic            stk_we;
  logic [SAW-1:0]  stk_waddr, stk_raddr;
  logic [FW-1:0]   stk_wdata, stk_rdata;
  bmm_ram #(.Width(FW), .Depth(SD)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  // First candidate right node at or beyond the cursor.
  logic [MaxRight-1:0] cand;
  logic                found;
  logic [RW-1:0]       pick;
  always_comb begin
    cand = 'b0;
    for (int i = 0; i < MaxRight; i++) begin
      cand[i] = row_q[i] && !vis_q[i] && (RCW'(i) >= cur_q) && (RCW'(i) < nr);
    end
  end
  // Priority pick runs across a registered row; a scan of independent bits.
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = MaxRight - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found = 1'b1;
        pick  = RW'(i);
      end
    end
  end

  logic [LW-1:0]  f_node;
  logic [RCW-1:0] f_cur;
  logic [RW-1:0]  f_chosen;
  assign {f_node, f_cur, f_chosen} = stk_rdata;

  // Sequencer.
  always_comb begin
    step_d = step_q; root_d = root_q; cnt_d = cnt_q; sp_d = sp_q; k_d = k_q;
    node_d = node_q; cur_d = cur_q; wipe_d = wipe_q; vis_d = vis_q; ownd_d = ownd_q;
    adj_we = 1'b0; adj_waddr = LW'(left_i); adj_wdata = adj_rdata;
    adj_raddr = LW'(left_i);
    own_we = 1'b0; own_waddr = pick; own_wdata = node_q; own_raddr = pick;
    stk_we = 1'b0; stk_waddr = SAW'(sp_q); stk_wdata = '0; stk_raddr = SAW'(sp_q);
    case (step_q)
      S_IDLE: begin
        if (cmd_i.clear_start) begin
          wipe_d = '0;
          step_d = S_CLR;
        end else if (cmd_i.solve_start) begin
          ownd_d = '0; root_d = '0; cnt_d = '0;
          step_d = S_ROOT;
        end else if (cmd_i.add_edge) begin
          node_d = LW'(left_i);
          cur_d  = RCW'(right_i);
          step_d = S_OINIT;
        end
      end
      // Add edge: row read was issued, now read-modify-write.
      S_OINIT: begin
        adj_we    = 1'b1;
        adj_waddr = node_q;
        adj_wdata = adj_rdata | (MaxRight'(1) << cur_q[RW-1:0]);
        step_d    = S_DONE;
      end
      // Clear one bitmap row per cycle.
      S_CLR: begin
        adj_we    = 1'b1;
        adj_waddr = wipe_q[LW-1:0];
        adj_wdata = '0;
        wipe_d    = wipe_q + 1'b1;
        if (wipe_q == LCW'(MaxLeft - 1)) step_d = S_DONE;
      end
      // Start a search from the next root.
      S_ROOT: begin
        if (root_q >= nl) begin
          step_d = S_DONE;
        end else begin
          vis_d = '0;
          stk_we = 1'b1; stk_waddr = '0;
          stk_wdata = {root_q[LW-1:0], RCW'(0), RW'(0)};
          sp_d = SW'(1);
          step_d = S_TOP;
        end
      end
      // Read the top frame.
      S_TOP: begin
        if (sp_q == '0) begin
          root_d = root_q + 1'b1;
          step_d = S_ROOT;
        end else begin
          stk_raddr = SAW'(sp_q - 1'b1);
          step_d = S_TOPW;
        end
      end
      // Frame ready; fetch its row.
      S_TOPW: begin
        node_d = f_node; cur_d = f_cur;
        adj_raddr = f_node;
        step_d = S_SCAN;
      end
      S_SCAN: begin
        step_d = S_OWNW;
      end
      // Row captured; choose the next right node.
      S_OWNW: begin
        if (!found) begin
          sp_d = sp_q - 1'b1;
          step_d = S_TOP;
        end else begin
          stk_we = 1'b1; stk_waddr = SAW'(sp_q - 1'b1);
          stk_wdata = {node_q, RCW'(pick) + 1'b1, pick};
          vis_d[pick] = 1'b1;
          own_raddr = pick;
          if (!ownd_q[pick]) begin
            k_d = '0;
            step_d = S_FLIP;
          end else begin
            cur_d = RCW'(pick);
            step_d = S_OWN;
          end
        end
      end
      // Owner known: push it if room and in range.
      S_OWN: begin
        if (sp_q <= SW'(MaxLeft) && LCW'(own_rdata) < nl) begin
          stk_we = 1'b1; stk_waddr = SAW'(sp_q);
          stk_wdata = {own_rdata, RCW'(0), RW'(0)};
          sp_d = sp_q + 1'b1;
        end
        step_d = S_TOP;
      end
      // Walk the stack and rewrite owners along the path.
      S_FLIP: begin
        if (k_q == sp_q) begin
          cnt_d = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
          sp_d = '0;
          root_d = root_q + 1'b1;
          step_d = S_ROOT;
        end else begin
          stk_raddr = SAW'(k_q);
          step_d = S_FLIPW;
        end
      end
      // Hold the read address so the frame is still on the read port.
      S_FLIPW: begin
        stk_raddr = SAW'(k_q);
        step_d = S_FLIPD;
      end
      S_FLIPD: begin
        own_we = 1'b1; own_waddr = f_chosen; own_wdata = f_node;
        ownd_d[f_chosen] = 1'b1;
        k_d = k_q + 1'b1;
        step_d = S_FLIP;
      end
      S_DONE: begin
        step_d = S_IDLE;
      end
      default: step_d = S_IDLE;
    endcase
  end
  assign row_load = (step_q == S_SCAN);

  // Reset starts a clearing pass over the bitmap.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_CLR;
      wipe_q <= '0;
      sp_q   <= '0;
      vis_q  <= '0;
      ownd_q <= '0;
    end else begin
      step_q <= step_d;
      wipe_q <= wipe_d;
      sp_q   <= sp_d;
      vis_q  <= vis_d;
      ownd_q <= ownd_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    root_q <= root_d; cnt_q <= cnt_d; k_q <= k_d; node_q <= node_d;
    cur_q <= cur_d;
    if (row_load) row_q <= adj_rdata;
  end

  assign sts_o.busy = (step_q != S_IDLE);
  assign sts_o.done = (step_q == S_DONE);
  assign count_o    = cnt_q;

  // The stack never grows past one frame per left node plus the root.
  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= SW'(SD))
    else $error("stack overflow");
  // A new command only arrives while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.solve_start || cmd_i.clear_start || cmd_i.add_edge) |-> step_q == S_IDLE)
    else $error("command while busy");
  // A picked node gets its visited mark set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_OWNW && found) |=> vis_q[$past(pick)])
    else $error("visited mark lost");
endmodule
`default_nettype wire

### hdl/bmm_ctrl.sv
// Controller of the matching core: input handshake, command issue and the
// result register. Depends on bmm_pkg.
`default_nettype none
module bmm_ctrl #(
  parameter int unsigned MaxLeft  = 256,
  parameter int unsigned MaxRight = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [bmm_pkg::OpW-1:0]  operation_i,
  input  wire logic [bmm_pkg::IdxW-1:0] left_index_i,
  input  wire logic [bmm_pkg::IdxW-1:0] right_index_i,
  input  wire logic [bmm_pkg::CountW-1:0] left_count_i,
  input  wire logic [bmm_pkg::CountW-1:0] right_count_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [bmm_pkg::CountW-1:0]    match_count_o,
  output bmm_pkg::bmm_cmd_t             cmd_o,
  input  wire bmm_pkg::bmm_sts_t        sts_i,
  input  wire logic [bmm_pkg::CountW-1:0] count_i
);
  import bmm_pkg::*;

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_WAIT  = 2'd1;

  logic [1:0] st_q, st_d;
  logic       solving_q, solving_d;
  logic       accept;
  logic       ov_q, ov_d;
  logic       in_range;

  // Hold input while working or while a result waits.
  assign in_stall_o = (st_q != C_IDLE) || sts_i.busy || ov_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = ({1'b0, left_index_i} < left_count_i) &&
                      ({1'b0, right_index_i} < right_count_i) &&
                      (32'(left_index_i) < MaxLeft) &&
                      (32'(right_index_i) < MaxRight);

  always_comb begin
    cmd_o.add_edge    = accept && operation_i == OP_ADD && in_range;
    cmd_o.clear_start = accept && operation_i == OP_CLEAR;
    cmd_o.solve_start = accept && operation_i == OP_SOLVE;
    st_d = st_q; solving_d = solving_q; ov_d = ov_q;
    if (out_valid_o && !out_stall_i) ov_d = 1'b0;
    case (st_q)
      C_IDLE: begin
        if (cmd_o.add_edge || cmd_o.clear_start || cmd_o.solve_start) begin
          st_d = C_WAIT;
          solving_d = cmd_o.solve_start;
        end
      end
      C_WAIT: begin
        if (sts_i.done) begin
          st_d = C_IDLE;
          if (solving_q) ov_d = 1'b1;
        end
      end
      default: st_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= C_IDLE; solving_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; solving_q <= solving_d; ov_q <= ov_d;
    end
  end

  // Capture the count when the solve finishes.
  always_ff @(posedge clk_i) begin
    if (st_q == C_WAIT && sts_i.done && solving_q) match_count_o <= count_i;
  end
  assign out_valid_o = ov_q;

  // No new item is taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ov_q |-> !accept)
    else $error("accept while result pending");
  // A result appears only after a solve completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(solving_q))
    else $error("result without solve");
  // A pending result holds while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> ov_q)
    else $error("result dropped");
endmodule
`default_nettype wire

### hdl/bipartite_max_matching_core.sv
// Channel  | handshake            | payload
// in       | in_valid_i/in_stall_o | operation_i, left_index_i, right_index_i
// out      | out_valid_o/out_stall_i | match_count_o
// cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// Add is a bitmap row read-modify-write; a dropped add or an unused code is
// accepted with no effect. Clear writes one bitmap row per cycle. Solve walks
// a search stack from each left node in use and flips owners along each path.
// Reset is asynchronous and starts a clearing pass over the bitmap; input
// stalls until it ends. Input is stalled until a result is taken.
`default_nettype none
module bipartite_max_matching_core #(
  parameter int unsigned MAX_LEFT  = 256,
  parameter int unsigned MAX_RIGHT = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  left_index_i,
  input  wire logic [7:0]  right_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [8:0]       match_count_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [8:0]  cfg_data_i
);
  import bmm_pkg::*;

  logic [CountW-1:0] left_count_q, right_count_q, count;
  bmm_cmd_t cmd;
  bmm_sts_t sts;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_count_q <= '0; right_count_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_LEFT_COUNT) left_count_q <= cfg_data_i;
      if (cfg_index_i == REG_RIGHT_COUNT) right_count_q <= cfg_data_i;
    end
  end

  bmm_ctrl #(.MaxLeft(MAX_LEFT), .MaxRight(MAX_RIGHT)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .left_index_i,
    .right_index_i, .left_count_i(left_count_q), .right_count_i(right_count_q),
    .out_valid_o, .out_stall_i, .match_count_o, .cmd_o(cmd), .sts_i(sts),
    .count_i(count)
  );

  bmm_datapath #(.MaxLeft(MAX_LEFT), .MaxRight(MAX_RIGHT)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .left_i(left_index_i), .right_i(right_index_i),
    .left_count_i(left_count_q), .right_count_i(right_count_q),
    .sts_o(sts), .count_o(count)
  );
endmodule
`default_nettype wire
